@@ sv/tet_pkg.sv @@
// tet_pkg: command codes, field widths and beat types for the tagged entry table
// no dependencies; imported by every module of the block
`default_nettype none

package tet_pkg;

   localparam int ADDR_BITS         = 64;
   localparam int UOP_BITS          = 8;
   localparam int HANDLE_FIELD_BITS = 8;
   localparam int COUNT_FIELD_BITS  = 5;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_LOOKUP = 2'd2;

   typedef struct packed {
      cmd_type                      cmd;
      logic [ADDR_BITS-1:0]         key_address;
      logic [UOP_BITS-1:0]          key_uop;
      logic [HANDLE_FIELD_BITS-1:0] handle_in;
   } tet_req_type;

   typedef struct packed {
      logic                         ok;
      logic [HANDLE_FIELD_BITS-1:0] handle_out;
      logic [COUNT_FIELD_BITS-1:0]  occupied_count;
   } tet_rsp_type;

endpackage

`default_nettype wire

@@ sv/tet_prio_enc.sv @@
// tet_prio_enc: lowest-index priority encoder over a request vector
// depends on tet_pkg
`default_nettype none

module tet_prio_enc
   import tet_pkg::*;
#(
   parameter int WIDTH    = 16,
   parameter int IDX_BITS = 4
) (
   input  wire logic [WIDTH-1:0]    req_vec,
   output logic                     found,
   output logic [IDX_BITS-1:0]      index
);

   // scan from the top so the lowest set bit wins
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (req_vec[i]) begin
            found = 1'b1;
            index = IDX_BITS'(i);
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/tagged_entry_table_top.sv @@
// tagged_entry_table_top: associative table keyed by address and micro-op number
// result path: an accepted command passes the command register and then the result
//   register, which drives rsp_strobe for exactly one cycle together with the result beat
// throughput: one command per cycle; busy never rises, the receiver cannot stall
// reset: synchronous; clears the entry valid bits, the count and the pipeline strobes
// depends on tet_pkg and tet_prio_enc
`default_nettype none

module tagged_entry_table_top
   import tet_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int HANDLE_BITS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire tet_req_type req_data,
   // result channel
   output logic             rsp_strobe,
   output tet_rsp_type      rsp_data
);

   localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

   // command register (input side of the single pass)
   logic        req_valid_ff;
   tet_req_type req_ff;

   // table state
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [ADDR_BITS-1:0]     addr_ff   [TABLE_ENTRIES];
   logic [UOP_BITS-1:0]      uop_ff    [TABLE_ENTRIES];
   logic [HANDLE_BITS-1:0]   handle_ff [TABLE_ENTRIES];
   logic [CNT_BITS-1:0]      count_ff, count_in;

   // result register
   logic        rsp_strobe_ff;
   tet_rsp_type rsp_ff, rsp_in;

   // search results
   logic [TABLE_ENTRIES-1:0] match_vec;
   logic                     match_found;
   logic [IDX_BITS-1:0]      match_idx;
   logic                     free_found;
   logic [IDX_BITS-1:0]      free_idx;

   logic                     wr_en;
   logic [HANDLE_BITS-1:0]   handle_wr;

   // every beat is taken in the cycle it is offered
   assign busy = 1'b0;

   // input register: payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      if (start) begin
         req_ff <= req_data;
      end
   end

   // parallel key compare, one comparator per entry
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_vec[i] = valid_ff[i]
                     && (addr_ff[i] == req_ff.key_address)
                     && (uop_ff[i] == req_ff.key_uop);
      end
   end

   // lowest matching entry for remove and lookup
   tet_prio_enc #(
      .WIDTH    (TABLE_ENTRIES),
      .IDX_BITS (IDX_BITS)
   ) u_match_enc (
      .req_vec (match_vec),
      .found   (match_found),
      .index   (match_idx)
   );

   // lowest free entry for insert; none found means the table is full
   tet_prio_enc #(
      .WIDTH    (TABLE_ENTRIES),
      .IDX_BITS (IDX_BITS)
   ) u_free_enc (
      .req_vec (~valid_ff),
      .found   (free_found),
      .index   (free_idx)
   );

   // only the low HANDLE_BITS of the handle are kept
   assign handle_wr = HANDLE_BITS'(req_ff.handle_in);

   // command decode and next table state
   always_comb begin
      valid_in          = valid_ff;
      count_in          = count_ff;
      wr_en             = 1'b0;
      rsp_in.ok         = 1'b0;
      rsp_in.handle_out = '0;
      if (req_valid_ff) begin
         unique case (req_ff.cmd)
            CMD_INSERT: begin
               // full table: fail and leave everything alone
               if (free_found) begin
                  valid_in[free_idx] = 1'b1;
                  count_in           = count_ff + CNT_BITS'(1);
                  wr_en              = 1'b1;
                  rsp_in.ok          = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (match_found) begin
                  valid_in[match_idx] = 1'b0;
                  count_in            = count_ff - CNT_BITS'(1);
                  rsp_in.ok           = 1'b1;
               end
            end
            CMD_LOOKUP: begin
               if (match_found) begin
                  rsp_in.ok         = 1'b1;
                  rsp_in.handle_out = HANDLE_FIELD_BITS'(handle_ff[match_idx]);
               end
            end
            default: begin
               // unused code: no operation, count still reported
            end
         endcase
      end
      // count wider than the field is masked
      rsp_in.occupied_count = COUNT_FIELD_BITS'(count_in);
   end

   // control state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // entry payload, written only on a successful insert
   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_ff[free_idx]   <= req_ff.key_address;
         uop_ff[free_idx]    <= req_ff.key_uop;
         handle_ff[free_idx] <= handle_wr;
      end
   end

   // result register: strobe for one cycle per command
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

@@ sv/tet_checker.sv @@
// tet_checker: port-level checks of the tagged entry table over time
// depends on tet_pkg; bound to tagged_entry_table_top at the end of this file
`default_nettype none

module tet_checker
   import tet_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire tet_req_type req_data,
   input wire logic        rsp_strobe,
   input wire tet_rsp_type rsp_data
);

   // every accepted beat gets a result strobe, through the command and result registers
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("tet: accepted command produced no result");

   // no result without a command
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("tet: result without a command");

   // a nonzero handle only comes back for a lookup that hit
   a_handle_only_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.handle_out != '0))
         |-> (rsp_data.ok && ($past(req_data.cmd, 2) == CMD_LOOKUP)))
      else $error("tet: handle returned outside a lookup hit");

   // the count moves by at most one, and only on success
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe))
         |-> ((rsp_data.occupied_count == $past(rsp_data.occupied_count))
           || (rsp_data.ok
               && ((rsp_data.occupied_count
                    == COUNT_FIELD_BITS'($past(rsp_data.occupied_count) + 1'b1))
                || (rsp_data.occupied_count
                    == COUNT_FIELD_BITS'($past(rsp_data.occupied_count) - 1'b1))))))
      else $error("tet: occupied count jumped");

endmodule

bind tagged_entry_table_top tet_checker u_tet_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

@@ tb/tagged_entry_table_top_tb.sv @@
// tagged_entry_table_top_tb: self-checking bench for the tagged entry table, directed
//   commands first, then randomized insert/remove/lookup traffic over a small key pool
// depends on tet_pkg and tagged_entry_table_top
`timescale 1ns / 100ps

module tagged_entry_table_top_tb;
   import tet_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int HANDLE_BITS   = 8;
   localparam logic [HANDLE_FIELD_BITS-1:0] HANDLE_MASK =
      HANDLE_FIELD_BITS'((1 << HANDLE_BITS) - 1);
   // code three has no name in the package; the block treats it as a no-op
   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int KEY_POOL_SIZE   = 24;
   localparam int CYCLE_LIMIT     = 200000;
   // drain wait after the last predicted result, so that stray result beats are still seen
   localparam int DRAIN_CYCLES    = 6;

   logic        clock;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   tet_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   tet_rsp_type rsp_data;

   // shadow copy of the table, updated once per accepted command beat
   logic                         slot_valid   [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0]         slot_address [TABLE_ENTRIES];
   logic [UOP_BITS-1:0]          slot_uop     [TABLE_ENTRIES];
   logic [HANDLE_FIELD_BITS-1:0] slot_handle  [TABLE_ENTRIES];
   int                           occupancy;

   tet_rsp_type predicted_rsp_q[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          idle_on        = 1'b0;

   // keys reused by random traffic so that removes and lookups actually hit
   logic [ADDR_BITS-1:0] pool_address [KEY_POOL_SIZE];
   logic [UOP_BITS-1:0]  pool_uop     [KEY_POOL_SIZE];

   tagged_entry_table_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .HANDLE_BITS  (HANDLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // lowest-numbered valid slot holding this key, or -1
   function automatic int find_slot(input logic [ADDR_BITS-1:0] addr,
                                    input logic [UOP_BITS-1:0] uop);
      int hit;
      hit = -1;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (slot_valid[i] && slot_address[i] == addr && slot_uop[i] == uop) hit = i;
      end
      return hit;
   endfunction

   // applies one command to the shadow table and returns the result it must produce
   function automatic tet_rsp_type apply_table_command(input tet_req_type beat);
      tet_rsp_type res;
      int          slot;
      res  = '0;
      slot = -1;
      case (beat.cmd)
         CMD_INSERT: begin
            // lowest free slot; a full table leaves everything as it is
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
               if (!slot_valid[i]) slot = i;
            end
            if (occupancy < TABLE_ENTRIES && slot >= 0) begin
               slot_valid[slot]   = 1'b1;
               slot_address[slot] = beat.key_address;
               slot_uop[slot]     = beat.key_uop;
               slot_handle[slot]  = beat.handle_in & HANDLE_MASK;
               occupancy++;
               res.ok = 1'b1;
            end
         end
         CMD_REMOVE: begin
            slot = find_slot(beat.key_address, beat.key_uop);
            if (occupancy > 0 && slot >= 0) begin
               slot_valid[slot] = 1'b0;
               occupancy--;
               res.ok = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            slot = find_slot(beat.key_address, beat.key_uop);
            if (slot >= 0) begin
               res.ok         = 1'b1;
               res.handle_out = slot_handle[slot] & HANDLE_MASK;
            end
         end
         default: ;  // unused code: no change, ok and handle stay zero
      endcase
      res.occupied_count = occupancy[COUNT_FIELD_BITS-1:0];
      return res;
   endfunction

   // monitor: results are checked against the oldest prediction, then any command
   // accepted at this edge is predicted; both read pre-edge values only
   always @(posedge clock) begin
      tet_rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (predicted_rsp_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  $display("%0t: ok mismatch, expected %0h, got %0h",
                           $time, want.ok, rsp_data.ok);
                  mismatch_count++;
               end
               if (rsp_data.handle_out !== want.handle_out) begin
                  $display("%0t: handle_out mismatch, expected %0h, got %0h",
                           $time, want.handle_out, rsp_data.handle_out);
                  mismatch_count++;
               end
               if (rsp_data.occupied_count !== want.occupied_count) begin
                  $display("%0t: occupied_count mismatch, expected %0d, got %0d",
                           $time, want.occupied_count, rsp_data.occupied_count);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) predicted_rsp_q.push_back(apply_table_command(req_data));
      end
   end

   // watchdog: a hung handshake or a lost result ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // drives one command beat and returns once it has been taken; start stays high
   // when the next beat follows directly, so it is never dropped and raised in one step
   task automatic send_command(input cmd_type cmd, input logic [ADDR_BITS-1:0] addr,
                               input logic [UOP_BITS-1:0] uop,
                               input logic [HANDLE_FIELD_BITS-1:0] handle);
      tet_req_type beat;
      beat.cmd         = cmd;
      beat.key_address = addr;
      beat.key_uop     = uop;
      beat.handle_in   = handle;
      req_data <= beat;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // random idle cycles between beats, roughly 29 in a hundred
      while (idle_on && $urandom_range(99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // one random beat; the percentages pick insert, remove and lookup, the rest is
   // the unused code; most keys come from the pool, a few are fresh
   task automatic send_random_command(input int insert_pct, input int remove_pct,
                                      input int lookup_pct);
      int                   pick;
      int                   key_idx;
      cmd_type              cmd;
      logic [ADDR_BITS-1:0] addr;
      logic [UOP_BITS-1:0]  uop;
      pick = $urandom_range(99);
      if (pick < insert_pct) cmd = CMD_INSERT;
      else if (pick < insert_pct + remove_pct) cmd = CMD_REMOVE;
      else if (pick < insert_pct + remove_pct + lookup_pct) cmd = CMD_LOOKUP;
      else cmd = CMD_UNUSED;
      if ($urandom_range(99) < 85) begin
         key_idx = $urandom_range(KEY_POOL_SIZE - 1);
         addr    = pool_address[key_idx];
         uop     = pool_uop[key_idx];
      end else begin
         addr = {$urandom, $urandom};
         uop  = UOP_BITS'($urandom);
      end
      send_command(cmd, addr, uop, HANDLE_FIELD_BITS'($urandom));
   endtask

   // empty table, field extremes, duplicate keys, near-miss keys, slot reuse
   task automatic test_directed;
      idle_on = 1'b0;
      send_command(CMD_LOOKUP, 64'h0123_4567_89ab_cdef, 8'h11, 8'h00);  // miss on empty
      send_command(CMD_REMOVE, 64'h0123_4567_89ab_cdef, 8'h11, 8'h00);  // remove on empty
      send_command(CMD_UNUSED, '1, '1, '1);
      send_command(CMD_INSERT, '1, '1, '1);                             // slot 0
      send_command(CMD_INSERT, '0, '0, '0);                             // slot 1
      send_command(CMD_INSERT, '1, '1, 8'h5a);                          // duplicate, slot 2
      send_command(CMD_LOOKUP, '1, '1, 8'h00);                          // first copy wins
      send_command(CMD_LOOKUP, '1, 8'hfe, 8'h00);                       // uop differs
      send_command(CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, '1, 8'h00);     // address differs
      send_command(CMD_REMOVE, '1, '1, 8'h33);                          // frees slot 0
      send_command(CMD_LOOKUP, '1, '1, 8'h00);                          // now the duplicate
      send_command(CMD_INSERT, 64'h8000_0000_0000_0001, 8'h80, 8'ha5);  // refills slot 0
      send_command(CMD_LOOKUP, 64'h8000_0000_0000_0001, 8'h80, 8'h00);
      send_command(CMD_LOOKUP, '0, '0, 8'hff);                          // stored handle 0
      send_command(CMD_UNUSED, 64'h8000_0000_0000_0001, 8'h80, 8'h00);  // no-op, table busy
      send_command(CMD_REMOVE, '0, '0, 8'h00);
      send_command(CMD_REMOVE, '0, '0, 8'h00);                          // already gone
      send_command(CMD_REMOVE, '1, '1, 8'h00);
      send_command(CMD_REMOVE, 64'h8000_0000_0000_0001, 8'h80, 8'h00);  // table empty again
   endtask

   // insert-heavy and remove-heavy phases in turn, so the table fills and drains
   task automatic test_fill_and_drain;
      idle_on = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         for (int n = 0; n < 140; n++) begin
            if (phase % 2 == 0) send_random_command(70, 15, 12);
            else send_random_command(12, 65, 20);
         end
      end
   endtask

   // long stretch with start held high every cycle
   task automatic test_back_to_back;
      idle_on = 1'b0;
      for (int n = 0; n < 400; n++) begin
         if ((n / 100) % 2 == 0) send_random_command(60, 20, 17);
         else send_random_command(15, 55, 27);
      end
   endtask

   // balanced mix with idling
   task automatic test_mixed_traffic;
      idle_on = 1'b1;
      for (int n = 0; n < 660; n++) send_random_command(35, 30, 32);
   endtask

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
      occupancy = 0;
      // key pool: some keys share an address, some differ from another in one bit
      for (int k = 0; k < KEY_POOL_SIZE; k++) begin
         pool_address[k] = {$urandom, $urandom};
         pool_uop[k]     = UOP_BITS'($urandom);
         if (k % 6 == 1) pool_address[k] = pool_address[k-1];
         if (k % 6 == 2) begin
            pool_address[k] = pool_address[k-1] ^ (64'd1 << $urandom_range(63));
            pool_uop[k]     = pool_uop[k-1];
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_drain();
      test_back_to_back();
      test_mixed_traffic();

      // drain: wait for every predicted beat, then a further drain wait for strays
      start <= 1'b0;
      @(posedge clock);
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
sv/tet_pkg.sv
sv/tet_prio_enc.sv
sv/tagged_entry_table_top.sv
sv/tet_checker.sv
tb/tagged_entry_table_top_tb.sv
